@@ hdl/nqfs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nqfs_pkg
// Shared constants and types for the first-solution N-queens search block.
// ----------------------------------------------------------------------------
package nqfs_pkg;

    // Default largest board side that the search supports.
    localparam int DEFAULT_MAX_SIZE = 16;

    // Fixed widths of the request and result fields.
    localparam int SIZE_W    = 5;
    localparam int COLUMN_W  = 4;
    localparam int QROW_W    = 4;

    // One result word as handed from the search controller to the output stage.
    typedef struct packed {
        logic                push;
        logic [COLUMN_W-1:0] column;
        logic [QROW_W-1:0]   queen_row;
        logic                found;
        logic                last;
    } nqfs_result_t;

endpackage

@@ hdl/nqfs_row_mem.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nqfs_row_mem
// Synchronous memory holding the queen row chosen for each column.
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module nqfs_row_mem #(
    parameter int DEPTH  = 16,
    parameter int DATA_W = 4
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_W-1:0]        wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem_array [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_array[waddr] <= wdata;
        end
    end

    // Read port; the data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_array[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/nqfs_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nqfs_ctrl
// Backtracking search controller. Between backtracks it tests one candidate
// row per cycle against row and diagonal occupancy masks, keeps the placement
// in the row memory, reads it back on backtrack and streams the final one out.
// ----------------------------------------------------------------------------
module nqfs_ctrl
    import nqfs_pkg::*;
#(
    parameter int MAX_SIZE = DEFAULT_MAX_SIZE
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [SIZE_W-1:0]           board_size,
    output logic                        idle,
    input  logic                        out_free,
    output nqfs_result_t                res,
    output logic                        mem_we,
    output logic [$clog2(MAX_SIZE)-1:0] mem_waddr,
    output logic [$clog2(MAX_SIZE)-1:0] mem_wdata,
    output logic                        mem_re,
    output logic [$clog2(MAX_SIZE)-1:0] mem_raddr,
    input  logic [$clog2(MAX_SIZE)-1:0] mem_rdata
);

    localparam int ROW_W  = $clog2(MAX_SIZE);
    localparam int CNT_W  = $clog2(MAX_SIZE + 1);
    localparam int DIAG_N = 2 * MAX_SIZE - 1;
    localparam int DIAG_W = $clog2(DIAG_N);
    localparam logic [SIZE_W:0]    SIZE_LIMIT = (SIZE_W + 1)'(MAX_SIZE);
    localparam logic [DIAG_W-1:0]  DIAG_OFS   = DIAG_W'(MAX_SIZE - 1);

    typedef enum logic [5:0] {
        ST_IDLE      = 6'b000001,
        ST_SEARCH    = 6'b000010,
        ST_BACK      = 6'b000100,
        ST_EMIT_RD   = 6'b001000,
        ST_EMIT_PUSH = 6'b010000,
        ST_FAIL      = 6'b100000
    } nqfs_state_t;

    nqfs_state_t         state_reg, state_next;
    logic [CNT_W-1:0]    n_reg, n_next;
    logic [CNT_W-1:0]    col_reg, col_next;
    logic [CNT_W-1:0]    cand_reg, cand_next;
    logic [ROW_W-1:0]    k_reg, k_next;
    logic [MAX_SIZE-1:0] row_used_reg, row_used_next;
    logic [DIAG_N-1:0]   diag_sum_reg, diag_sum_next;
    logic [DIAG_N-1:0]   diag_dif_reg, diag_dif_next;

    logic [CNT_W-1:0]    col_dec;
    logic                cand_ge_n;
    logic [ROW_W-1:0]    sel_row;
    logic [ROW_W-1:0]    sel_col;
    logic [DIAG_W-1:0]   sum_idx;
    logic [DIAG_W-1:0]   dif_idx;
    logic                safe;
    logic                size_bad;

    // Occupancy indices for the row under test, or for the row being lifted
    // during a backtrack.
    assign col_dec   = col_reg - 1'b1;
    assign cand_ge_n = (cand_reg >= n_reg);
    assign sel_row   = (state_reg == ST_BACK) ? mem_rdata : cand_reg[ROW_W-1:0];
    assign sel_col   = col_reg[ROW_W-1:0];
    assign sum_idx   = DIAG_W'(sel_row) + DIAG_W'(sel_col);
    assign dif_idx   = DIAG_W'(sel_row) + DIAG_OFS - DIAG_W'(sel_col);
    assign safe      = !row_used_reg[sel_row] && !diag_sum_reg[sum_idx]
                       && !diag_dif_reg[dif_idx];
    assign size_bad  = (board_size == '0) || ({1'b0, board_size} > SIZE_LIMIT);

    // Memory ports: a placement writes the column's row; a backtrack reads the
    // previous column, and the emission pass reads each column in turn.
    assign mem_we    = (state_reg == ST_SEARCH) && !cand_ge_n && safe;
    assign mem_waddr = sel_col;
    assign mem_wdata = sel_row;
    assign mem_re    = ((state_reg == ST_SEARCH) && cand_ge_n && (col_reg != '0))
                       || (state_reg == ST_EMIT_RD);
    assign mem_raddr = (state_reg == ST_EMIT_RD) ? k_reg : col_dec[ROW_W-1:0];

    assign idle = (state_reg == ST_IDLE);

    // Search and emission sequencing.
    always_comb
    begin
        state_next    = state_reg;
        n_next        = n_reg;
        col_next      = col_reg;
        cand_next     = cand_reg;
        k_next        = k_reg;
        row_used_next = row_used_reg;
        diag_sum_next = diag_sum_reg;
        diag_dif_next = diag_dif_reg;
        res           = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    n_next        = CNT_W'(board_size);
                    col_next      = '0;
                    cand_next     = '0;
                    row_used_next = '0;
                    diag_sum_next = '0;
                    diag_dif_next = '0;
                    state_next    = size_bad ? ST_FAIL : ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                if (cand_ge_n)
                begin
                    if (col_reg == '0)
                    begin
                        state_next = ST_FAIL;
                    end
                    else
                    begin
                        col_next   = col_dec;
                        state_next = ST_BACK;
                    end
                end
                else if (safe)
                begin
                    row_used_next[sel_row] = 1'b1;
                    diag_sum_next[sum_idx] = 1'b1;
                    diag_dif_next[dif_idx] = 1'b1;
                    col_next               = col_reg + 1'b1;
                    cand_next              = '0;
                    if (col_reg + 1'b1 == n_reg)
                    begin
                        k_next     = '0;
                        state_next = ST_EMIT_RD;
                    end
                end
                else
                begin
                    cand_next = cand_reg + 1'b1;
                end
            end
            ST_BACK:
            begin
                // Lift the queen of this column and resume one row below it.
                row_used_next[sel_row] = 1'b0;
                diag_sum_next[sum_idx] = 1'b0;
                diag_dif_next[dif_idx] = 1'b0;
                cand_next              = CNT_W'(mem_rdata) + 1'b1;
                state_next             = ST_SEARCH;
            end
            ST_EMIT_RD:
            begin
                state_next = ST_EMIT_PUSH;
            end
            ST_EMIT_PUSH:
            begin
                if (out_free)
                begin
                    res.push      = 1'b1;
                    res.column    = COLUMN_W'(k_reg);
                    res.queen_row = QROW_W'(mem_rdata);
                    res.found     = 1'b1;
                    res.last      = (CNT_W'(k_reg) + 1'b1 == n_reg);
                    if (res.last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        k_next     = k_reg + 1'b1;
                        state_next = ST_EMIT_RD;
                    end
                end
            end
            ST_FAIL:
            begin
                if (out_free)
                begin
                    res.push   = 1'b1;
                    res.last   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            n_reg     <= '0;
            col_reg   <= '0;
            cand_reg  <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            n_reg     <= n_next;
            col_reg   <= col_next;
            cand_reg  <= cand_next;
            k_reg     <= k_next;
        end
    end

    // Occupancy masks.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_used_reg <= '0;
            diag_sum_reg <= '0;
            diag_dif_reg <= '0;
        end
        else
        begin
            row_used_reg <= row_used_next;
            diag_sum_reg <= diag_sum_next;
            diag_dif_reg <= diag_dif_next;
        end
    end

    // A result word is only handed over when the output stage can take it.
    a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
        res.push |-> out_free)
        else $error("result pushed into a full output stage");

    // While searching, the column under work lies inside the board.
    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEARCH) |-> (col_reg < n_reg))
        else $error("search column beyond board size");

    // A backtrack read is always consumed in the following cycle.
    a_back_resume: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_BACK) |=> (state_reg == ST_SEARCH))
        else $error("backtrack did not resume the search");

    // The final word of a request returns the controller to idle.
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (res.push && res.last) |=> (state_reg == ST_IDLE))
        else $error("controller busy after final word");

endmodule

@@ hdl/n_queens_first_solution.sv @@
`timescale 1ns / 1ps
// Sequence: a size of zero or above MAX_SIZE goes straight to the fail state, which
// hands its single word to the output register. Other sizes search at one candidate
// row per cycle, with a row memory read per backtrack, then emit each word through a
// read state and a push state that waits for the output register to be free.
// Requests are taken one at a time; the search loop over the row memory sets the time.
// Reset clears the controller, the occupancy masks and the output word valid.
// ----------------------------------------------------------------------------
// n_queens_first_solution
// Finds the first placement of n non-attacking queens on an n by n board by
// depth-first backtracking and streams out one row word per column.
// ----------------------------------------------------------------------------
module n_queens_first_solution
    import nqfs_pkg::*;
#(
    parameter int MAX_SIZE = DEFAULT_MAX_SIZE
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  logic [SIZE_W-1:0]   board_size,
    output logic                res_valid,
    input  logic                res_stall,
    output logic [COLUMN_W-1:0] column,
    output logic [QROW_W-1:0]   queen_row,
    output logic                found,
    output logic                last
);

    localparam int ROW_W = $clog2(MAX_SIZE);

    logic                ctrl_idle;
    logic                out_free;
    nqfs_result_t        ctrl_res;
    logic                mem_we;
    logic [ROW_W-1:0]    mem_waddr;
    logic [ROW_W-1:0]    mem_wdata;
    logic                mem_re;
    logic [ROW_W-1:0]    mem_raddr;
    logic [ROW_W-1:0]    mem_rdata;

    logic                res_valid_reg;
    logic [COLUMN_W-1:0] column_reg;
    logic [QROW_W-1:0]   queen_row_reg;
    logic                found_reg;
    logic                last_reg;

    // Requests are taken only while the controller is idle.
    assign req_stall = !ctrl_idle;

    // The output register can load when empty or when its word leaves now.
    assign out_free = !res_valid_reg || !res_stall;

    nqfs_row_mem #(
        .DEPTH  (MAX_SIZE),
        .DATA_W (ROW_W)
    ) u_row_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    nqfs_ctrl #(
        .MAX_SIZE (MAX_SIZE)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (req_valid && !req_stall),
        .board_size (board_size),
        .idle       (ctrl_idle),
        .out_free   (out_free),
        .res        (ctrl_res),
        .mem_we     (mem_we),
        .mem_waddr  (mem_waddr),
        .mem_wdata  (mem_wdata),
        .mem_re     (mem_re),
        .mem_raddr  (mem_raddr),
        .mem_rdata  (mem_rdata)
    );

    // Output word valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (ctrl_res.push)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    // Output word payload.
    always_ff @(posedge clk)
    begin
        if (ctrl_res.push)
        begin
            column_reg    <= ctrl_res.column;
            queen_row_reg <= ctrl_res.queen_row;
            found_reg     <= ctrl_res.found;
            last_reg      <= ctrl_res.last;
        end
    end

    assign res_valid = res_valid_reg;
    assign column    = column_reg;
    assign queen_row = queen_row_reg;
    assign found     = found_reg;
    assign last      = last_reg;

endmodule

@@ tb/n_queens_first_solution_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// n_queens_first_solution_tb
// Self-checking bench for the first-solution N-queens search block. Board
// size requests are sent over the request channel, and an in-bench
// backtracking solver predicts the words that each one must produce. Every
// accepted result word is compared field by field with the oldest predicted
// word. The run covers directed sizes, random sizes under several idling
// mixes, a long output hold-off and a full drain pause.
// ----------------------------------------------------------------------------
module n_queens_first_solution_tb;
    import nqfs_pkg::*;

    localparam int MAX_BOARD = DEFAULT_MAX_SIZE;
    localparam int HOLD_CYCLES = 1500;

    // One predicted result word.
    typedef struct packed {
        logic [COLUMN_W-1:0] column;
        logic [QROW_W-1:0]   queen_row;
        logic                found;
        logic                last;
    } queen_word_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                req_valid;
    logic                req_stall;
    logic [SIZE_W-1:0]   board_size;
    logic                res_valid;
    logic                res_stall;
    logic [COLUMN_W-1:0] column;
    logic [QROW_W-1:0]   queen_row;
    logic                found;
    logic                last;

    queen_word_t queen_words_due[$];
    logic [3:0]  queen_rows [MAX_BOARD];
    int          search_steps;
    int          mismatch_count = 0;
    int          cycle_count = 0;
    int          cycle_limit = 200000;
    int          sender_idle_pct = 0;
    int          receiver_stall_pct = 0;
    int          hold_pending = 0;
    int          hold_left = 0;

    n_queens_first_solution uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .board_size (board_size),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .column     (column),
        .queen_row  (queen_row),
        .found      (found),
        .last       (last)
    );

    // Free-running clock, 12 ns period.
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Depth-first search over columns, rows tried in ascending order. Fills
    // queen_rows and counts loop steps so the run limit can follow the work.
    function automatic bit place_queens(input int n);
        int  col;
        int  row;
        int  i;
        bit  safe;
        col = 0;
        row = 0;
        while (col < n)
        begin
            search_steps++;
            if (row >= n)
            begin
                if (col == 0)
                    return 1'b0;
                col--;
                row = queen_rows[col] + 1;
            end
            else
            begin
                safe = 1'b1;
                for (i = 0; i < col; i++)
                begin
                    if (queen_rows[i] == row || queen_rows[i] + col == row + i ||
                        queen_rows[i] + i == row + col)
                        safe = 1'b0;
                end
                if (safe)
                begin
                    queen_rows[col] = row[3:0];
                    col++;
                    row = 0;
                end
                else
                begin
                    row++;
                end
            end
        end
        return 1'b1;
    endfunction

    // Queue the words that an accepted request must produce.
    task automatic predict_request(input logic [SIZE_W-1:0] n);
        queen_word_t w;
        int          k;
        search_steps = 0;
        if (n == 0 || n > MAX_BOARD || !place_queens(int'(n)))
        begin
            // No placement, size zero, or size beyond the supported board.
            w = '{column: '0, queen_row: '0, found: 1'b0, last: 1'b1};
            queen_words_due.push_back(w);
        end
        else
        begin
            for (k = 0; k < n; k++)
            begin
                w.column    = k[COLUMN_W-1:0];
                w.queen_row = queen_rows[k];
                w.found     = 1'b1;
                w.last      = (k + 1 == n);
                queen_words_due.push_back(w);
            end
        end
        cycle_limit += 4 * (3 * search_steps + 8 * n) + 200;
    endtask

    // Offer one request, with random idle cycles first, and hold it until taken.
    task automatic send_request(input logic [SIZE_W-1:0] n);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid  <= 1'b1;
        board_size <= n;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        predict_request(n);
    endtask

    function automatic int queue_size();
        return queen_words_due.size();
    endfunction

    // Stop offering and wait until every predicted word has come back.
    task automatic wait_drained();
        req_valid <= 1'b0;
        while (queue_size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Mostly solvable sizes, small ones favored; the rest no-solution or out of range.
    function automatic logic [SIZE_W-1:0] pick_size();
        int r;
        r = $urandom_range(99);
        if (r < 55)
            return SIZE_W'($urandom_range(8, 1));
        if (r < 84)
            return SIZE_W'($urandom_range(12, 9));
        if (r < 88)
            return SIZE_W'($urandom_range(16, 13));
        if (r < 94)
            return SIZE_W'($urandom_range(3, 0));
        return SIZE_W'($urandom_range(31, 17));
    endfunction

    task automatic run_random_requests(input int count);
        int i;
        for (i = 0; i < count; i++)
        begin
            send_request(pick_size());
            // Sender pause halfway through: let the block empty completely.
            if (i == count / 2)
                wait_drained();
        end
    endtask

    // Every size from zero to the largest board, plus out-of-range sizes.
    task automatic test_directed_sizes();
        int n;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        for (n = 0; n <= MAX_BOARD; n++)
            send_request(SIZE_W'(n));
        send_request(SIZE_W'(MAX_BOARD + 1));
        send_request(SIZE_W'(24));
        send_request(SIZE_W'(31));
        wait_drained();
    endtask

    task automatic test_back_to_back();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        run_random_requests(32);
    endtask

    task automatic test_sender_gaps();
        sender_idle_pct    = 49;
        receiver_stall_pct = 0;
        run_random_requests(32);
    endtask

    task automatic test_receiver_stalls();
        sender_idle_pct    = 0;
        receiver_stall_pct = 49;
        run_random_requests(32);
    endtask

    task automatic test_both_idle();
        sender_idle_pct    = 28;
        receiver_stall_pct = 28;
        run_random_requests(32);
    endtask

    // Long output hold-off while requests keep coming, so the input backs up.
    task automatic test_output_hold();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        hold_pending       = HOLD_CYCLES;
        cycle_limit       += 2 * HOLD_CYCLES;
        repeat (8) send_request(SIZE_W'($urandom_range(7, 4)));
        wait_drained();
    endtask

    // Output stall: random per cycle, or held high through a requested hold-off.
    initial
    begin
        res_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_pending > 0)
            begin
                hold_left    = hold_pending;
                hold_pending = 0;
            end
            if (hold_left > 0)
            begin
                res_stall <= 1'b1;
                hold_left--;
            end
            else
            begin
                res_stall <= ($urandom_range(99) < receiver_stall_pct);
            end
        end
    end

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    // Compare each accepted result word with the oldest prediction.
    always @(posedge clk)
    begin
        queen_word_t w;
        if (rst_n && res_valid && !res_stall)
        begin
            if (queen_words_due.size() == 0)
            begin
                $error("word with no request pending: column %0d, queen_row %0d",
                       column, queen_row);
                mismatch_count++;
            end
            else
            begin
                w = queen_words_due.pop_front();
                check_field("column", w.column, column);
                check_field("queen_row", w.queen_row, queen_row);
                check_field("found", w.found, found);
                check_field("last", w.last, last);
            end
        end
    end

    // Run limit, grown as requests are predicted.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > cycle_limit)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        rst_n      <= 1'b0;
        req_valid  <= 1'b0;
        board_size <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_sizes();
        test_back_to_back();
        test_sender_gaps();
        test_receiver_stalls();
        test_both_idle();
        test_output_hold();

        wait_drained();
        repeat (20) @(posedge clk);
        if (mismatch_count == 0 && queen_words_due.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

@@ files.f @@
hdl/nqfs_pkg.sv
hdl/nqfs_row_mem.sv
hdl/nqfs_ctrl.sv
hdl/n_queens_first_solution.sv
tb/n_queens_first_solution_tb.sv
